// ----- rtl/task_slot_scheduler_assert.svh -----
// Assertion macros shared by the scheduler modules.
`ifndef TASK_SLOT_SCHEDULER_ASSERT_SVH
`define TASK_SLOT_SCHEDULER_ASSERT_SVH

// A condition that must hold at every rising clock edge outside reset.
`define TSS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define TSS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- rtl/tss_pkg.sv -----
package tss_pkg;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      ACT_MAKE     = 3'd0,
      ACT_KILL     = 3'd1,
      ACT_KILL_CUR = 3'd2,
      ACT_WAIT     = 3'd3,
      ACT_TICK     = 3'd4,
      ACT_NEXT     = 3'd5,
      ACT_SET_CUR  = 3'd6
   } act_type;

   typedef enum logic [2:0] {
      STS_OK           = 3'd0,
      STS_FAIL         = 3'd1,
      STS_WAITING      = 3'd2,
      STS_WAIT_STARTED = 3'd3,
      STS_NO_CURRENT   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_POST,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      SCAN_FREE,
      SCAN_ACTIVE,
      SCAN_VALID
   } scan_mode_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic scan_step;
      logic post;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_hit;
      logic scan_last;
   } dp_status_type;

endpackage

// ----- rtl/task_slot_scheduler.sv -----
// Task-slot scheduler: a table of SLOT_COUNT task slots with valid, active, waiting and
// kill-pending flags and a TIME_WIDTH-bit wake deadline each, plus a current-slot register
// and a no-task flag. One action is handled per request beat and gives one response beat.
// Actions that need no search go from S_IDLE through S_EXEC to S_DONE, which loads the
// response into the output register once that register is free; make without a slot
// number, next, kill of an active slot and a wait poll that is still pending run a
// round-robin search through the slot table in S_SCAN, one slot per cycle, examining
// 1 to SLOT_COUNT slots, and pass through S_POST before S_DONE. A new request is taken
// once the previous response has been loaded, even while that response still waits to
// be taken. Times are taken modulo 2^TIME_WIDTH.
module task_slot_scheduler #(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action[2:0], use_id[3], task_id[11:4], wait_duration[43:12], now[75:44]
   input  logic [tss_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], found[3], result_slot[7:4], no_task[8], timer_irq_request[9]
   output logic [tss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   tss_pkg::cmd_type       cmd;
   tss_pkg::dp_status_type sts;

   tss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tss_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- rtl/tss_datapath.sv -----
`include "task_slot_scheduler_assert.svh"

module tss_datapath #(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tss_pkg::cmd_type                cmd,
   output tss_pkg::dp_status_type          sts,
   // action[2:0], use_id[3], task_id[11:4], wait_duration[43:12], now[75:44]
   input  logic [tss_pkg::REQ_DATA_W-1:0]  req_tdata,
   // status[2:0], found[3], result_slot[7:4], no_task[8], timer_irq_request[9]
   output logic [tss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   // Latched request.
   tss_pkg::act_type        act_ff, act_in;
   logic                    use_ff, use_in;
   logic [7:0]              id_ff, id_in;
   logic [TIME_WIDTH-1:0]   dur_ff, dur_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;

   // Slot table.
   logic [SLOT_COUNT-1:0]   valid_ff, valid_in;
   logic [SLOT_COUNT-1:0]   active_ff, active_in;
   logic [SLOT_COUNT-1:0]   waiting_ff, waiting_in;
   logic [SLOT_COUNT-1:0]   killp_ff, killp_in;
   logic [TIME_WIDTH-1:0]   deadline_ff [SLOT_COUNT];
   logic [TIME_WIDTH-1:0]   deadline_in [SLOT_COUNT];
   logic                    present_ff, present_in;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic                    no_task_ff, no_task_in;

   // Scan unit.
   tss_pkg::scan_mode_type  mode_ff, mode_in;
   logic [SLOT_W-1:0]       pos_ff, pos_in;
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   logic                    sc_found_ff, sc_found_in;
   logic [SLOT_W-1:0]       sc_slot_ff, sc_slot_in;

   // Result being built, and the output register.
   tss_pkg::status_type     res_status_ff, res_status_in;
   logic                    res_found_ff, res_found_in;
   logic [3:0]              res_slot_ff, res_slot_in;
   logic                    res_irq_ff, res_irq_in;
   tss_pkg::status_type     out_status_ff, out_status_in;
   logic                    out_found_ff, out_found_in;
   logic [3:0]              out_slot_ff, out_slot_in;
   logic                    out_no_task_ff, out_no_task_in;
   logic                    out_irq_ff, out_irq_in;

   logic                    id_in_range;
   logic [SLOT_W-1:0]       id_slot;
   logic [SLOT_W-1:0]       cur_next;
   logic [SLOT_W-1:0]       pos_next;
   logic                    wait_expired;
   logic                    scan_hit;
   logic                    found_next;
   logic                    claim_en;
   logic [SLOT_W-1:0]       claim_slot;

   assign id_in_range  = id_ff < 8'(SLOT_COUNT);
   assign id_slot      = id_ff[SLOT_W-1:0];
   assign cur_next     = (cur_ff == LAST_SLOT) ? '0 : cur_ff + 1'b1;
   assign pos_next     = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign wait_expired = now_ff > deadline_ff[cur_ff];

   always_comb begin
      case (mode_ff)
         tss_pkg::SCAN_FREE:   scan_hit = !valid_ff[pos_ff];
         tss_pkg::SCAN_ACTIVE: scan_hit = active_ff[pos_ff];
         tss_pkg::SCAN_VALID:  scan_hit = valid_ff[pos_ff];
         default:              scan_hit = 1'b0;
      endcase
   end

   // Meeting the current slot again on a valid-flag scan means there is no other task.
   assign found_next = sc_found_ff &&
                       !(mode_ff == tss_pkg::SCAN_VALID && sc_slot_ff == cur_ff);

   always_comb begin
      sts.scan_hit  = scan_hit;
      sts.scan_last = cnt_ff == LAST_SLOT;
      case (act_ff)
         tss_pkg::ACT_MAKE: sts.need_scan = !use_ff;
         tss_pkg::ACT_KILL: sts.need_scan = use_ff && id_in_range && active_ff[id_slot];
         tss_pkg::ACT_WAIT: sts.need_scan = present_ff && waiting_ff[cur_ff] && !wait_expired;
         tss_pkg::ACT_NEXT: sts.need_scan = 1'b1;
         default:           sts.need_scan = 1'b0;
      endcase
   end

   always_comb begin
      act_in         = act_ff;
      use_in         = use_ff;
      id_in          = id_ff;
      dur_in         = dur_ff;
      now_in         = now_ff;
      valid_in       = valid_ff;
      active_in      = active_ff;
      waiting_in     = waiting_ff;
      killp_in       = killp_ff;
      deadline_in    = deadline_ff;
      present_in     = present_ff;
      cur_in         = cur_ff;
      no_task_in     = no_task_ff;
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      sc_found_in    = sc_found_ff;
      sc_slot_in     = sc_slot_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_slot_in    = res_slot_ff;
      res_irq_in     = res_irq_ff;
      out_status_in  = out_status_ff;
      out_found_in   = out_found_ff;
      out_slot_in    = out_slot_ff;
      out_no_task_in = out_no_task_ff;
      out_irq_in     = out_irq_ff;
      claim_en       = 1'b0;
      claim_slot     = id_slot;

      if (cmd.latch) begin
         act_in = tss_pkg::act_type'(req_tdata[2:0]);
         use_in = req_tdata[3];
         id_in  = req_tdata[11:4];
         dur_in = TIME_WIDTH'(req_tdata[43:12]);
         now_in = TIME_WIDTH'(req_tdata[75:44]);
      end

      if (cmd.exec) begin
         res_status_in = tss_pkg::STS_OK;
         res_found_in  = 1'b0;
         res_slot_in   = '0;
         res_irq_in    = 1'b0;
         sc_found_in   = 1'b0;
         cnt_in        = '0;
         if (act_ff == tss_pkg::ACT_MAKE) begin
            mode_in = tss_pkg::SCAN_FREE;
            pos_in  = '0;
         end else if (present_ff) begin
            mode_in = tss_pkg::SCAN_VALID;
            pos_in  = cur_next;
         end else begin
            mode_in = tss_pkg::SCAN_ACTIVE;
            pos_in  = '0;
         end

         case (act_ff)
            tss_pkg::ACT_MAKE: begin
               res_status_in = tss_pkg::STS_FAIL;
               if (use_ff && id_in_range && !valid_ff[id_slot]) begin
                  claim_en = 1'b1;
               end
            end
            tss_pkg::ACT_KILL: begin
               if (!use_ff) begin
                  valid_in   = '0;
                  active_in  = '0;
                  waiting_in = '0;
                  killp_in   = '0;
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     deadline_in[i] = '0;
                  end
                  no_task_in = 1'b1;
                  present_in = 1'b0;
               end else if (!id_in_range) begin
                  res_status_in = tss_pkg::STS_FAIL;
               end else if (active_ff[id_slot]) begin
                  // The slot is marked for kill; the follow-up scan decides
                  // whether any task is left.
                  killp_in[id_slot]    = 1'b1;
                  valid_in[id_slot]    = 1'b0;
                  active_in[id_slot]   = 1'b0;
                  waiting_in[id_slot]  = 1'b0;
                  deadline_in[id_slot] = '0;
               end
            end
            tss_pkg::ACT_KILL_CUR: begin
               if (present_ff) begin
                  valid_in[cur_ff]    = 1'b0;
                  active_in[cur_ff]   = 1'b0;
                  waiting_in[cur_ff]  = 1'b0;
                  killp_in[cur_ff]    = 1'b0;
                  deadline_in[cur_ff] = '0;
                  present_in          = 1'b0;
               end
            end
            tss_pkg::ACT_WAIT: begin
               if (!present_ff) begin
                  res_status_in = tss_pkg::STS_NO_CURRENT;
               end else if (waiting_ff[cur_ff]) begin
                  if (wait_expired) begin
                     waiting_in[cur_ff] = 1'b0;
                  end else begin
                     res_status_in = tss_pkg::STS_WAITING;
                  end
               end else begin
                  deadline_in[cur_ff] = now_ff + dur_ff;
                  waiting_in[cur_ff]  = 1'b1;
                  res_irq_in          = 1'b1;
                  res_status_in       = tss_pkg::STS_WAIT_STARTED;
               end
            end
            tss_pkg::ACT_TICK: begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (waiting_ff[i] && valid_ff[i] && deadline_ff[i] < now_ff) begin
                     active_in[i]  = 1'b1;
                     waiting_in[i] = 1'b0;
                  end
               end
            end
            tss_pkg::ACT_NEXT: begin
            end
            tss_pkg::ACT_SET_CUR: begin
               if (!use_ff) begin
                  present_in = 1'b0;
               end else if (id_in_range) begin
                  present_in = 1'b1;
                  cur_in     = id_slot;
               end else begin
                  res_status_in = tss_pkg::STS_FAIL;
               end
            end
            default: begin
               res_status_in = tss_pkg::STS_FAIL;
            end
         endcase
      end

      if (cmd.scan_step) begin
         if (scan_hit) begin
            sc_found_in = 1'b1;
            sc_slot_in  = pos_ff;
         end else begin
            pos_in = pos_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end

      if (cmd.post) begin
         case (act_ff)
            tss_pkg::ACT_MAKE: begin
               if (sc_found_ff) begin
                  claim_en   = 1'b1;
                  claim_slot = sc_slot_ff;
               end
            end
            tss_pkg::ACT_KILL: begin
               if (!found_next) begin
                  present_in = 1'b0;
                  no_task_in = 1'b1;
               end
            end
            tss_pkg::ACT_WAIT: begin
               res_irq_in = found_next;
            end
            tss_pkg::ACT_NEXT: begin
               res_found_in = found_next;
               res_slot_in  = found_next ? 4'(sc_slot_ff) : 4'd0;
            end
            default: begin
            end
         endcase
      end

      if (claim_en) begin
         valid_in[claim_slot]   = 1'b1;
         active_in[claim_slot]  = 1'b1;
         waiting_in[claim_slot] = 1'b0;
         killp_in[claim_slot]   = 1'b0;
         if (!present_ff) begin
            present_in = 1'b1;
            cur_in     = claim_slot;
         end
         no_task_in    = 1'b0;
         res_status_in = tss_pkg::STS_OK;
         res_found_in  = 1'b1;
         res_slot_in   = 4'(claim_slot);
      end

      if (cmd.load_out) begin
         out_status_in  = res_status_ff;
         out_found_in   = res_found_ff;
         out_slot_in    = res_slot_ff;
         out_no_task_in = no_task_ff;
         out_irq_in     = res_irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         active_ff  <= '0;
         waiting_ff <= '0;
         killp_ff   <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            deadline_ff[i] <= '0;
         end
         present_ff <= 1'b0;
         cur_ff     <= '0;
         no_task_ff <= 1'b1;
      end else begin
         valid_ff    <= valid_in;
         active_ff   <= active_in;
         waiting_ff  <= waiting_in;
         killp_ff    <= killp_in;
         deadline_ff <= deadline_in;
         present_ff  <= present_in;
         cur_ff      <= cur_in;
         no_task_ff  <= no_task_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      use_ff         <= use_in;
      id_ff          <= id_in;
      dur_ff         <= dur_in;
      now_ff         <= now_in;
      mode_ff        <= mode_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      sc_found_ff    <= sc_found_in;
      sc_slot_ff     <= sc_slot_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      res_slot_ff    <= res_slot_in;
      res_irq_ff     <= res_irq_in;
      out_status_ff  <= out_status_in;
      out_found_ff   <= out_found_in;
      out_slot_ff    <= out_slot_in;
      out_no_task_ff <= out_no_task_in;
      out_irq_ff     <= out_irq_in;
   end

   assign rsp_tdata = tss_pkg::RSP_DATA_W'({out_irq_ff, out_no_task_ff, out_slot_ff,
                                            out_found_ff, out_status_ff});

   `TSS_ASSERT_ALWAYS(a_kill_pending_not_valid, clock, reset, (killp_ff & valid_ff) == '0, "slot both valid and kill pending")
   `TSS_ASSERT_ALWAYS(a_active_is_valid, clock, reset, (active_ff & ~valid_ff) == '0, "active slot is not valid")

endmodule

// ----- rtl/tss_ctrl.sv -----
`include "task_slot_scheduler_assert.svh"

module tss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tss_pkg::dp_status_type sts,
   output tss_pkg::cmd_type       cmd
);

   tss_pkg::state_type state_ff, state_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               out_free;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tss_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = tss_pkg::S_EXEC;
            end
         end
         tss_pkg::S_EXEC: begin
            state_in = sts.need_scan ? tss_pkg::S_SCAN : tss_pkg::S_DONE;
         end
         tss_pkg::S_SCAN: begin
            if (sts.scan_hit || sts.scan_last) begin
               state_in = tss_pkg::S_POST;
            end
         end
         tss_pkg::S_POST: begin
            state_in = tss_pkg::S_DONE;
         end
         tss_pkg::S_DONE: begin
            if (out_free) begin
               state_in = tss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tss_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         tss_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         tss_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         tss_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         tss_pkg::S_POST: begin
            cmd.post = 1'b1;
         end
         tss_pkg::S_DONE: begin
            cmd.load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   // A new beat loaded into the output register wins over the one leaving it.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tss_pkg::S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   `TSS_ASSERT_NEXT(a_accept_runs_exec, clock, reset, req_tvalid && req_tready, state_ff == tss_pkg::S_EXEC, "accepted beat not executed")
   `TSS_ASSERT_NEXT(a_hit_ends_scan, clock, reset, state_ff == tss_pkg::S_SCAN && sts.scan_hit, state_ff == tss_pkg::S_POST, "scan did not stop on a hit")

endmodule
